FILE: rtl/mh64_pkg.sv
// Shared types and constants for the MurmurHash64A block.
// No dependencies; mh64_front, mh64_queue, mh64_mul, mh64_back and the top import this package.
package mh64_pkg;

	localparam logic [63:0] MUR_M = 64'hc6a4a7935bd1e995;
	localparam int unsigned MUR_R = 47;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// one classified key word as it travels from the front end to the back end
	typedef struct packed {
		logic [63:0] word;       // raw word for a full word, masked low bytes for a tail
		logic [31:0] key_length;
		logic        first_item;
		logic        last_item;
		logic        full;
		logic        tail;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_K1,
		ST_K2,
		ST_H,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic busy;
		logic fin;
	} back_stat_t;

endpackage

FILE: rtl/mh64_in_if.sv
// Input channel of the hash block: valid/ready handshake and one key word.
// Depends on nothing.
interface mh64_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        first_item;
	logic        last_item;
	logic [31:0] key_length;

	modport source (output valid, output data_word, output byte_count, output first_item,
		output last_item, output key_length, input ready);
	modport sink (input valid, input data_word, input byte_count, input first_item,
		input last_item, input key_length, output ready);
endinterface

FILE: rtl/mh64_out_if.sv
// Output channel of the hash block: valid/ready handshake and the 64-bit hash.
// Depends on nothing.
interface mh64_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;

	modport source (output valid, output hash_value, input ready);
	modport sink (input valid, input hash_value, output ready);
endinterface

FILE: rtl/mh64_front.sv
// Front end: classifies an incoming key word as full, tail or empty and masks tail bytes.
// Depends on mh64_pkg.
module mh64_front import mh64_pkg::*; (
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        first_item,
	input  logic        last_item,
	input  logic [31:0] key_length,
	output item_t       item
);

	logic [63:0] byte_mask;
	logic        full;

	// counts of 8 and above mix as a full word
	assign full = byte_count[3];

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			byte_mask[i*8 +: 8] = (3'(i) < byte_count[2:0]) ? 8'hff : 8'h00;
		end
	end

	always_comb begin
		item.word       = full ? data_word : (data_word & byte_mask);
		item.key_length = key_length;
		item.first_item = first_item;
		item.last_item  = last_item;
		item.full       = full;
		item.tail       = !full && (byte_count[2:0] != 3'd0);
	end

endmodule

FILE: rtl/mh64_queue.sv
// Short item queue between the front end and the back end.
// Depends on mh64_pkg (item_t, QUEUE_DEPTH).
module mh64_queue import mh64_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop,
	output item_t pop_item
);

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/mh64_mul.sv
// Multiplier by the constant M, low 64 bits of the product.
// Depends on mh64_pkg (MUR_M). Partial products are registered, the sum follows.
module mh64_mul import mh64_pkg::*; (
	input  logic        clk,
	input  logic        load,
	input  logic [63:0] a,
	output logic [63:0] prod
);

	logic [63:0] pp_ll_q;
	logic [31:0] pp_hl_q;
	logic [31:0] pp_lh_q;

	// only the low 32 bits of the cross products reach the low 64 bits of the result
	always_ff @(posedge clk) begin
		if (load) begin
			pp_ll_q <= 64'(a[31:0]) * 64'(MUR_M[31:0]);
			pp_hl_q <= 32'(a[63:32] * MUR_M[31:0]);
			pp_lh_q <= 32'(a[31:0] * MUR_M[63:32]);
		end
	end

	assign prod = pp_ll_q + {pp_hl_q + pp_lh_q, 32'd0};

endmodule

FILE: rtl/mh64_back.sv
// Back end: sequences seed, word mix and finalization through one shared multiplier.
// Depends on mh64_pkg and mh64_mul.
module mh64_back import mh64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  item_t       q_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] hash_value,
	output back_stat_t  stat
);

	state_t      state_q;
	state_t      state_d;
	logic        phase_q;
	logic        phase_d;
	logic        step_done;
	item_t       cur_q;
	logic [63:0] x_q;
	logic [63:0] h_q;
	logic [63:0] hash_q;
	logic        out_valid_q;
	logic [63:0] mul_a;
	logic [63:0] prod;

	function automatic state_t after_seed(item_t it);
		state_t s;
		if (it.full) begin
			s = ST_K1;
		end else if (it.tail) begin
			s = ST_H;
		end else if (it.last_item) begin
			s = ST_FIN;
		end else begin
			s = ST_IDLE;
		end
		return s;
	endfunction

	mh64_mul u_mul (
		.clk  (clk),
		.load (!phase_q),
		.a    (mul_a),
		.prod (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		q_pop     = 1'b0;
		step_done = 1'b0;
		mul_a     = '0;
		case (state_q)
			ST_IDLE: begin
				q_pop = q_valid;
				if (q_valid) begin
					state_d = q_item.first_item ? ST_SEED : after_seed(q_item);
				end
			end
			ST_SEED: mul_a = {32'd0, cur_q.key_length};
			ST_K1:   mul_a = cur_q.word;
			ST_K2:   mul_a = x_q;
			ST_H:    mul_a = h_q ^ x_q;
			ST_FIN:  mul_a = h_q ^ (h_q >> MUR_R);
			default: mul_a = '0;
		endcase
		if (state_q != ST_IDLE) begin
			if (!phase_q) begin
				phase_d = 1'b1;
			end else if (state_q != ST_FIN || !out_valid_q || out_ready) begin
				// hold finalization while the previous hash still waits at the output
				phase_d   = 1'b0;
				step_done = 1'b1;
				case (state_q)
					ST_SEED: state_d = after_seed(cur_q);
					ST_K1:   state_d = ST_K2;
					ST_K2:   state_d = ST_H;
					ST_H:    state_d = cur_q.last_item ? ST_FIN : ST_IDLE;
					default: state_d = ST_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
			x_q   <= q_item.word;
		end
		if (step_done) begin
			case (state_q)
				ST_K1:   x_q <= prod ^ (prod >> MUR_R);
				ST_K2:   x_q <= prod;
				ST_FIN:  hash_q <= prod ^ (prod >> MUR_R);
				default: ;
			endcase
		end
	end

	// running hash starts from zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= '0;
		end else if (step_done && (state_q inside {ST_SEED, ST_H})) begin
			h_q <= prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_done && state_q == ST_FIN) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;
	assign stat.busy  = (state_q != ST_IDLE);
	assign stat.fin   = (state_q == ST_FIN);

endmodule

FILE: rtl/murmur2_64a_hash_top.sv
// MurmurHash64A (seed 0) over a key fed as 64-bit little-endian words. A two-entry
// queue takes words while the back end works; the back end handles one word at a
// time through one multiplier by M. Per word, once it is pulled from the queue: no
// multiply step for a word of 0 bytes, the H step for a tail word, the K1, K2 and
// H steps for a full word; the first word of a key adds the seed step and the last
// adds finalization, held while the previous hash waits at the output. The hash is
// held in an output register, so the next key can start while it waits to be taken.
// Depends on mh64_pkg, mh64_in_if, mh64_out_if, mh64_front, mh64_queue, mh64_back.
module murmur2_64a_hash_top import mh64_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mh64_in_if.sink    in_ch,
	mh64_out_if.source out_ch
);

	item_t      front_item;
	item_t      q_item;
	logic       q_valid;
	logic       q_pop;
	logic       q_in_ready;
	back_stat_t stat;

	mh64_front u_front (
		.data_word  (in_ch.data_word),
		.byte_count (in_ch.byte_count),
		.first_item (in_ch.first_item),
		.last_item  (in_ch.last_item),
		.key_length (in_ch.key_length),
		.item       (front_item)
	);

	mh64_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_ch.valid),
		.push_ready (q_in_ready),
		.push_item  (front_item),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_item   (q_item)
	);

	assign in_ch.ready = q_in_ready;

	mh64_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_item     (q_item),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.hash_value (out_ch.hash_value),
		.stat       (stat)
	);

`ifndef ASSERT_OFF
	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("back end popped an empty queue");

	a_empty_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |-> q_in_ready)
		else $error("empty queue refuses input");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(stat.fin))
		else $error("hash shown without finalization");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !stat.busy)
		else $error("item pulled while back end busy");
`endif

endmodule
